@@ hdl/bti_pkg.sv @@
// Shared types, constants and widths for the breakpoint table interpolator.
package bti_pkg;

    localparam int REG_COUNT   = 8;
    localparam int REG_W       = 25;
    localparam int CFG_IDX_W   = 3;
    localparam int LEVEL_W     = 16;
    localparam int ALPHA_W     = 8;
    localparam int OPAC_W      = 17;
    localparam int FRAC_BITS   = 17;
    localparam int PROD_W      = LEVEL_W + ALPHA_W;
    localparam int REM_W       = PROD_W + FRAC_BITS;
    localparam int STEP_W      = $clog2(FRAC_BITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int NUM_POINTS_DEFAULT = 8;

    localparam int VALID_BIT   = 24;
    localparam int BRIGHT_HI   = 23;
    localparam int BRIGHT_LO   = 8;
    localparam int ALPHA_HI    = 7;

    localparam logic [OPAC_W-1:0]  DEFAULT_Q16 = 17'd58982;
    localparam logic [ALPHA_W-1:0] ALPHA_FULL  = 8'd255;

    typedef logic [REG_COUNT-1:0][REG_W-1:0] point_array_t;

    typedef struct packed {
        logic               hit;
        logic               interp;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] prev_b;
        logic [ALPHA_W-1:0] prev_a;
        logic [LEVEL_W-1:0] eb;
        logic [ALPHA_W-1:0] ea;
    } seg_desc_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_SCAN,
        FS_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_MUL,
        BS_LOAD,
        BS_DIV,
        BS_DONE
    } back_state_t;

endpackage

@@ hdl/bti_front.sv @@
// Front end: accepts a level and scans the breakpoint table to classify its segment.
module bti_front #(
    parameter int NUM_POINTS = bti_pkg::NUM_POINTS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [bti_pkg::LEVEL_W-1:0]      s_level,
    input  bti_pkg::point_array_t            points,
    output logic                             q_push,
    output bti_pkg::seg_desc_t               q_wdata,
    input  logic                             q_full
);

    localparam int IDX_W = $clog2(NUM_POINTS);

    bti_pkg::front_state_t            state_reg, state_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic                             have_prev_reg, have_prev_next;
    logic [bti_pkg::LEVEL_W-1:0]      prev_b_reg, prev_b_next;
    logic [bti_pkg::ALPHA_W-1:0]      prev_a_reg, prev_a_next;
    logic [bti_pkg::LEVEL_W-1:0]      level_reg, level_next;
    bti_pkg::seg_desc_t               desc_reg, desc_next;

    logic [bti_pkg::REG_W-1:0]        entry;
    logic                             entry_v;
    logic [bti_pkg::LEVEL_W-1:0]      entry_b;
    logic [bti_pkg::ALPHA_W-1:0]      entry_a;
    logic                             last_entry;

    assign entry      = points[idx_reg];
    assign entry_v    = entry[bti_pkg::VALID_BIT];
    assign entry_b    = entry[bti_pkg::BRIGHT_HI:bti_pkg::BRIGHT_LO];
    assign entry_a    = entry[bti_pkg::ALPHA_HI:0];
    assign last_entry = (idx_reg == IDX_W'(NUM_POINTS - 1));

    assign s_ready = (state_reg == bti_pkg::FS_IDLE);
    assign q_push  = (state_reg == bti_pkg::FS_PUSH) && !q_full;
    assign q_wdata = desc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bti_pkg::FS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        idx_reg       <= idx_next;
        have_prev_reg <= have_prev_next;
        prev_b_reg    <= prev_b_next;
        prev_a_reg    <= prev_a_next;
        level_reg     <= level_next;
        desc_reg      <= desc_next;
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        have_prev_next = have_prev_reg;
        prev_b_next    = prev_b_reg;
        prev_a_next    = prev_a_reg;
        level_next     = level_reg;
        desc_next      = desc_reg;
        unique case (state_reg)
            bti_pkg::FS_IDLE: begin
                if (s_valid) begin
                    level_next     = s_level;
                    idx_next       = '0;
                    have_prev_next = 1'b0;
                    state_next     = bti_pkg::FS_SCAN;
                end
            end
            bti_pkg::FS_SCAN: begin
                if (entry_v && (entry_b >= level_reg)) begin
                    desc_next.hit    = 1'b1;
                    desc_next.interp = have_prev_reg && (entry_b > prev_b_reg);
                    desc_next.level  = level_reg;
                    desc_next.prev_b = prev_b_reg;
                    desc_next.prev_a = prev_a_reg;
                    desc_next.eb     = entry_b;
                    desc_next.ea     = entry_a;
                    state_next       = bti_pkg::FS_PUSH;
                end else begin
                    if (entry_v) begin
                        have_prev_next = 1'b1;
                        prev_b_next    = entry_b;
                        prev_a_next    = entry_a;
                    end
                    if (last_entry) begin
                        desc_next.hit    = have_prev_next;
                        desc_next.interp = 1'b0;
                        desc_next.level  = level_reg;
                        desc_next.prev_b = prev_b_next;
                        desc_next.prev_a = prev_a_next;
                        desc_next.eb     = prev_b_next;
                        desc_next.ea     = prev_a_next;
                        state_next       = bti_pkg::FS_PUSH;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            bti_pkg::FS_PUSH: begin
                if (!q_full) begin
                    state_next = bti_pkg::FS_IDLE;
                end
            end
            default: begin
                state_next = bti_pkg::FS_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/bti_fifo.sv @@
// Short queue of classified segment descriptors between the front and back ends.
module bti_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bti_pkg::seg_desc_t  wdata,
    output logic                full,
    input  logic                pop,
    output bti_pkg::seg_desc_t  rdata,
    output logic                empty
);

    localparam int DEPTH = bti_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bti_pkg::seg_desc_t  slots_reg [DEPTH];
    logic [PTR_W-1:0]    wptr_reg, wptr_next;
    logic [PTR_W-1:0]    rptr_reg, rptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slots_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
        if (do_push) begin
            slots_reg[wptr_reg] <= wdata;
        end
    end

endmodule

@@ hdl/bti_back.sv @@
// Back end: forms the interpolation fraction and divides it bit by bit into Q1.16.
module bti_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    output logic                          q_pop,
    input  bti_pkg::seg_desc_t            q_rdata,
    input  logic                          q_empty,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bti_pkg::OPAC_W-1:0]    m_opacity_q16,
    output logic                          m_table_hit
);

    localparam int LW = bti_pkg::LEVEL_W;
    localparam int PW = bti_pkg::PROD_W;
    localparam int RW = bti_pkg::REM_W;
    localparam int SW = bti_pkg::STEP_W;
    localparam int OW = bti_pkg::OPAC_W;

    bti_pkg::back_state_t  state_reg, state_next;
    bti_pkg::seg_desc_t    desc_reg, desc_next;
    logic [PW-1:0]         num_reg, num_next;
    logic [PW-1:0]         den_reg, den_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic [RW-1:0]         dsh_reg, dsh_next;
    logic [OW-1:0]         quo_reg, quo_next;
    logic [SW-1:0]         step_reg, step_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OW-1:0]         m_opac_reg, m_opac_next;
    logic                  m_hit_reg, m_hit_next;

    logic [LW-1:0]         d_sel, t_sel;
    logic [PW-1:0]         prod_prev, prod_ent, prod_den;
    logic                  out_free;

    assign out_free      = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_opacity_q16 = m_opac_reg;
    assign m_table_hit   = m_hit_reg;

    assign d_sel     = desc_reg.interp ? (desc_reg.eb - desc_reg.prev_b) : LW'(1);
    assign t_sel     = desc_reg.interp ? (desc_reg.level - desc_reg.prev_b) : LW'(1);
    assign prod_prev = PW'(desc_reg.prev_a) * PW'(d_sel - t_sel);
    assign prod_ent  = PW'(desc_reg.ea) * PW'(t_sel);
    assign prod_den  = PW'(bti_pkg::ALPHA_FULL) * PW'(d_sel);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bti_pkg::BS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        desc_reg   <= desc_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        m_opac_reg <= m_opac_next;
        m_hit_reg  <= m_hit_next;
    end

    always_comb begin
        state_next   = state_reg;
        desc_next    = desc_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        dsh_next     = dsh_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        m_opac_next  = m_opac_reg;
        m_hit_next   = m_hit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        q_pop        = 1'b0;
        unique case (state_reg)
            bti_pkg::BS_IDLE: begin
                if (!q_empty) begin
                    q_pop     = 1'b1;
                    desc_next = q_rdata;
                    if (q_rdata.hit) begin
                        state_next = bti_pkg::BS_MUL;
                    end else begin
                        quo_next   = bti_pkg::DEFAULT_Q16;
                        state_next = bti_pkg::BS_DONE;
                    end
                end
            end
            bti_pkg::BS_MUL: begin
                num_next   = prod_prev + prod_ent;
                den_next   = prod_den;
                state_next = bti_pkg::BS_LOAD;
            end
            bti_pkg::BS_LOAD: begin
                rem_next   = (RW'(num_reg) << bti_pkg::FRAC_BITS) + RW'(den_reg);
                dsh_next   = RW'({den_reg, 1'b0}) << (bti_pkg::FRAC_BITS - 1);
                quo_next   = '0;
                step_next  = SW'(bti_pkg::FRAC_BITS - 1);
                state_next = bti_pkg::BS_DIV;
            end
            bti_pkg::BS_DIV: begin
                if (rem_reg >= dsh_reg) begin
                    rem_next = rem_reg - dsh_reg;
                    quo_next = {quo_reg[OW-2:0], 1'b1};
                end else begin
                    quo_next = {quo_reg[OW-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                if (step_reg == '0) begin
                    state_next = bti_pkg::BS_DONE;
                end else begin
                    step_next = step_reg - SW'(1);
                end
            end
            bti_pkg::BS_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_opac_next  = quo_reg;
                    m_hit_next   = desc_reg.hit;
                    state_next   = bti_pkg::BS_IDLE;
                end
            end
            default: begin
                state_next = bti_pkg::BS_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/breakpoint_table_interpolator.sv @@
// Top level of the breakpoint table interpolator: configuration registers and the
// front end, queue and back end.
//
// Each level transaction is mapped to an opacity in unsigned Q1.16 by piecewise-linear
// interpolation over up to NUM_POINTS breakpoints held in the point registers. The
// front end accepts a level and scans the table entries one by one (NUM_POINTS at most),
// then hands the classified segment to a two-entry queue. The back end forms the
// products, sets up the divider, runs the bit-serial restoring divider and then loads
// the output register; it takes a new segment from the queue only after loading the
// previous result. A new level is accepted while an earlier result waits in the output
// register. Write the point registers only while the block is idle.
module breakpoint_table_interpolator #(
    parameter int NUM_POINTS = bti_pkg::NUM_POINTS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [bti_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bti_pkg::REG_W-1:0]           cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bti_pkg::LEVEL_W-1:0]         s_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bti_pkg::OPAC_W-1:0]          m_opacity_q16,
    output logic                                m_table_hit
);

    bti_pkg::point_array_t  points_reg, points_next;
    bti_pkg::seg_desc_t     q_wdata, q_rdata;
    logic                   q_push, q_full, q_pop, q_empty;

    always_comb begin
        points_next = points_reg;
        if (cfg_wen) begin
            points_next[cfg_index] = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_reg <= '0;
        end else begin
            points_reg <= points_next;
        end
    end

    bti_front #(
        .NUM_POINTS (NUM_POINTS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_level (s_level),
        .points  (points_reg),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_full  (q_full)
    );

    bti_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    bti_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_pop         (q_pop),
        .q_rdata       (q_rdata),
        .q_empty       (q_empty),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_opacity_q16 (m_opacity_q16),
        .m_table_hit   (m_table_hit)
    );

endmodule

@@ tb/sv/breakpoint_table_interpolator_test.sv @@
// Self-checking testbench for the breakpoint table interpolator.
module breakpoint_table_interpolator_test;
    import bti_pkg::*;

    localparam int NUM_POINTS  = 8;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic [OPAC_W-1:0] opacity;
        logic              hit;
    } opacity_result_t;

    typedef enum int {
        RM_OPEN,
        RM_RANDOM,
        RM_HOLD
    } ready_mode_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [LEVEL_W-1:0]   s_level = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [OPAC_W-1:0]    m_opacity_q16;
    logic                 m_table_hit;

    logic [REG_W-1:0] point_model [REG_COUNT] = '{default: '0};
    logic [REG_W-1:0] table_plan [REG_COUNT] = '{default: '0};
    opacity_result_t  opacity_pending [$];
    int               mismatch_count = 0;
    int               cycle_count = 0;
    int               burst_left = 0;
    ready_mode_t      ready_mode = RM_OPEN;
    int               ready_left = 0;

    breakpoint_table_interpolator #(
        .NUM_POINTS(NUM_POINTS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wen(cfg_wen),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_level(s_level),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_opacity_q16(m_opacity_q16),
        .m_table_hit(m_table_hit)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [REG_W-1:0] make_point(input logic valid, input int bright,
                                                     input int alpha);
        return {valid, LEVEL_W'(bright), ALPHA_W'(alpha)};
    endfunction

    // Rounded num / den in Q1.16 with ties going up.
    function automatic logic [OPAC_W-1:0] round_q16(input longint unsigned num,
                                                    input longint unsigned den);
        return OPAC_W'((num * (longint'(1) << FRAC_BITS) + den) / (2 * den));
    endfunction

    function automatic opacity_result_t predict_opacity(input logic [LEVEL_W-1:0] lvl);
        opacity_result_t    res;
        logic               have_prev;
        logic               decided;
        logic [LEVEL_W-1:0] prev_b;
        logic [LEVEL_W-1:0] eb;
        logic [ALPHA_W-1:0] prev_a;
        logic [ALPHA_W-1:0] ea;
        longint unsigned    span;
        longint unsigned    offset;
        res.opacity = DEFAULT_Q16;
        res.hit = 1'b0;
        have_prev = 1'b0;
        decided = 1'b0;
        prev_b = '0;
        prev_a = '0;
        for (int i = 0; i < NUM_POINTS; i++) begin
            if (!decided && point_model[i][VALID_BIT]) begin
                eb = point_model[i][BRIGHT_HI:BRIGHT_LO];
                ea = point_model[i][ALPHA_HI:0];
                if (eb >= lvl) begin
                    if (!have_prev || eb <= prev_b) begin
                        res.opacity = round_q16(ea, ALPHA_FULL);
                    end else begin
                        span = eb - prev_b;
                        offset = lvl - prev_b;
                        res.opacity = round_q16(prev_a * (span - offset) + ea * offset,
                                                ALPHA_FULL * span);
                    end
                    res.hit = 1'b1;
                    decided = 1'b1;
                end else begin
                    have_prev = 1'b1;
                    prev_b = eb;
                    prev_a = ea;
                end
            end
        end
        if (!decided && have_prev) begin
            res.opacity = round_q16(prev_a, ALPHA_FULL);
            res.hit = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        $display("mismatch at cycle %0d: %s, expected %0d, got %0d",
                 cycle_count, what, want, got);
        mismatch_count++;
    endtask

    task automatic wait_for_drain();
        while (opacity_pending.size() != 0) @(posedge aclk);
    endtask

    // The block must be idle here: nothing pending and no level offered.
    task automatic load_table();
        for (int i = 0; i < REG_COUNT; i++) begin
            cfg_wen <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= table_plan[i];
            @(posedge aclk);
            point_model[i] = table_plan[i];
        end
        cfg_wen <= 1'b0;
    endtask

    task automatic reconfigure();
        s_valid <= 1'b0;
        wait_for_drain();
        repeat (4) @(posedge aclk);
        load_table();
    endtask

    task automatic send_level(input logic [LEVEL_W-1:0] lvl);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_level <= lvl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        opacity_pending.push_back(predict_opacity(lvl));
    endtask

    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            ready_left = (ready_mode == RM_HOLD) ? $urandom_range(1, 60)
                                                 : $urandom_range(10, 150);
        end
        ready_left--;
        case (ready_mode)
            RM_OPEN:   m_ready <= 1'b1;
            RM_RANDOM: m_ready <= 1'($urandom_range(0, 1));
            default:   m_ready <= 1'b0;
        endcase
    end

    always @(posedge aclk) begin : check_results
        opacity_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (opacity_pending.size() == 0) begin
                report_mismatch("result with no level pending", 0, m_opacity_q16);
            end else begin
                want = opacity_pending.pop_front();
                if (m_opacity_q16 !== want.opacity)
                    report_mismatch("opacity_q16", want.opacity, m_opacity_q16);
                if (m_table_hit !== want.hit)
                    report_mismatch("table_hit", want.hit, m_table_hit);
            end
        end
    end

    task automatic test_empty_table();
        send_level(16'h0000);
        send_level(16'hFFFF);
    endtask

    task automatic test_single_point();
        table_plan = '{default: '0};
        table_plan[7] = make_point(1'b1, 1000, 128);
        reconfigure();
        send_level(16'd999);
        send_level(16'd1000);
        send_level(16'd1001);
    endtask

    task automatic test_interpolation();
        table_plan[0] = make_point(1'b1, 0, 0);
        table_plan[1] = make_point(1'b1, 256, 255);
        table_plan[2] = make_point(1'b1, 4096, 17);
        table_plan[3] = make_point(1'b0, 100, 5);
        table_plan[4] = make_point(1'b1, 65535, 200);
        table_plan[5] = make_point(1'b0, 3, 250);
        table_plan[6] = make_point(1'b0, 65535, 255);
        table_plan[7] = make_point(1'b0, 0, 1);
        reconfigure();
        send_level(16'd0);
        send_level(16'd128);
        send_level(16'd256);
        send_level(16'd257);
        send_level(16'd2000);
        send_level(16'd4096);
        send_level(16'd30000);
        send_level(16'd65535);
    endtask

    // Above the table the last valid entry in scan order decides, not the highest one.
    task automatic test_descending_table();
        table_plan = '{default: '0};
        table_plan[0] = make_point(1'b1, 40000, 10);
        table_plan[1] = make_point(1'b1, 30000, 250);
        table_plan[2] = make_point(1'b0, 50000, 77);
        table_plan[3] = make_point(1'b1, 20000, 99);
        reconfigure();
        send_level(16'd0);
        send_level(16'd35000);
        send_level(16'd40001);
        send_level(16'd65535);
    endtask

    task automatic test_extreme_tables();
        table_plan = '{default: {REG_W{1'b1}}};
        reconfigure();
        send_level(16'd0);
        send_level(16'd65535);
        table_plan = '{default: '0};
        reconfigure();
        send_level(16'd12345);
    endtask

    task automatic test_random_tables();
        int kind;
        int valid_pct;
        int bright;
        int k;
        int lvl;
        for (int phase = 0; phase < 10; phase++) begin
            kind = $urandom_range(0, 9);
            valid_pct = (kind == 1) ? 25 : 85;
            bright = $urandom_range(0, 8191);
            for (int i = 0; i < REG_COUNT; i++) begin
                if (kind == 0) begin
                    table_plan[i] = REG_W'($urandom);
                end else begin
                    table_plan[i] = make_point($urandom_range(0, 99) < valid_pct, bright,
                                               $urandom_range(0, 255));
                    bright += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 16383);
                    if (bright > 65535)
                        bright = 65535;
                end
            end
            reconfigure();
            for (int n = 0; n < 200; n++) begin
                if ($urandom_range(0, 9) < 7) begin
                    k = $urandom_range(0, REG_COUNT - 1);
                    lvl = int'(table_plan[k][BRIGHT_HI:BRIGHT_LO]) + $urandom_range(0, 4) - 2;
                    if (lvl < 0)
                        lvl = 0;
                    if (lvl > 65535)
                        lvl = 65535;
                end else begin
                    lvl = $urandom_range(0, 65535);
                end
                send_level(LEVEL_W'(lvl));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_single_point();
        test_interpolation();
        test_descending_table();
        test_extreme_tables();
        test_random_tables();
        s_valid <= 1'b0;
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
